// ===== design/lkv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the lru key/value cache
// state codes, action codes and the structs that pass between the modules
// ----------------------------------------------------------------------------
package lkv_pkg;

    // width of the capacity register
    localparam int CFG_W = 5;

    // capacity after reset
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // action codes
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // write enables of the entry memories
    typedef struct packed {
        logic key_we;
        logic val_we;
    } t_mem_wr;

    // result flags from the sequencer
    typedef struct packed {
        logic done;
        logic found;
        logic evicted;
    } t_res_flags;

endpackage

// ===== design/lkv_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_mem: key and value storage of the cache entries
// one write port and one registered read port, shared address for both arrays
// ----------------------------------------------------------------------------
module lkv_mem
    import lkv_pkg::*;
#(
    parameter int ENTRIES     = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    input  t_mem_wr                    i_wr,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  logic [KEY_WIDTH-1:0]       i_wr_key,
    input  logic [VALUE_WIDTH-1:0]     i_wr_val,
    output logic [KEY_WIDTH-1:0]       o_rd_key,
    output logic [VALUE_WIDTH-1:0]     o_rd_val
);

    logic [KEY_WIDTH-1:0]   r_key_mem [ENTRIES];
    logic [VALUE_WIDTH-1:0] r_val_mem [ENTRIES];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.key_we) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
        end
        if (i_wr.val_we) begin
            r_val_mem[i_wr_addr] <= i_wr_val;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_key <= r_key_mem[i_rd_addr];
            o_rd_val <= r_val_mem[i_rd_addr];
        end
    end

endmodule

// ===== design/lkv_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_ctrl: scan sequencer, valid bits and recency ranks
// walks the entries one a cycle through a single key and rank compare, then
// applies the hit, insert or eviction in the update cycle
// ----------------------------------------------------------------------------
module lkv_ctrl
    import lkv_pkg::*;
#(
    parameter int ENTRIES     = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_action,
    input  logic [KEY_WIDTH-1:0]         i_key,
    input  logic [VALUE_WIDTH-1:0]       i_write_value,
    input  logic                         i_clear,
    input  logic [$clog2(ENTRIES+1)-1:0] i_cap_eff,
    input  logic [KEY_WIDTH-1:0]         i_mem_key,
    input  logic [VALUE_WIDTH-1:0]       i_mem_val,
    output logic                         o_mem_rd_en,
    output logic [$clog2(ENTRIES)-1:0]   o_mem_rd_addr,
    output t_mem_wr                      o_mem_wr,
    output logic [$clog2(ENTRIES)-1:0]   o_mem_wr_addr,
    output logic [KEY_WIDTH-1:0]         o_mem_wr_key,
    output logic [VALUE_WIDTH-1:0]       o_mem_wr_val,
    output logic                         o_busy,
    output t_res_flags                   o_res,
    output logic [VALUE_WIDTH-1:0]       o_rd_value,
    output logic [KEY_WIDTH-1:0]         o_ev_key,
    output logic [$clog2(ENTRIES+1)-1:0] o_occ
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES+1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    t_state r_state, n_state;

    // latched item
    logic                   r_action;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_wval;

    // scan pointers
    logic             r_issue;
    logic [IDX_W-1:0] r_idx;
    logic             r_dvld;
    logic [IDX_W-1:0] r_didx;

    // scan findings
    logic                   r_hit;
    logic [IDX_W-1:0]       r_hit_idx;
    logic [RANK_W-1:0]      r_hit_rank;
    logic [VALUE_WIDTH-1:0] r_hit_val;
    logic                   r_vic;
    logic [IDX_W-1:0]       r_vic_idx;
    logic [KEY_WIDTH-1:0]   r_vic_key;
    logic                   r_free;
    logic [IDX_W-1:0]       r_free_idx;

    // entry state
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [RANK_W-1:0]  r_rank [ENTRIES];
    logic [RANK_W-1:0]  n_rank [ENTRIES];
    logic [CNT_W-1:0]   r_count, n_count;

    logic              w_accept;
    logic [CNT_W-1:0]  w_oldest_full;
    logic [RANK_W-1:0] w_oldest;
    logic              w_dvalid;
    logic [RANK_W-1:0] w_drank;
    logic              w_match;
    logic              w_is_vic;
    logic              w_put;
    logic              w_full;
    logic              w_slot_vic;
    logic              w_slot_free;
    logic              w_ins;
    logic [IDX_W-1:0]  w_slot;

    assign w_accept = i_start && !o_busy;

    // compare unit on the entry coming out of memory
    assign w_oldest_full = r_count - CNT_W'(1);
    assign w_oldest      = w_oldest_full[RANK_W-1:0];
    assign w_dvalid      = r_valid[r_didx];
    assign w_drank       = r_rank[r_didx];
    assign w_match       = r_dvld && w_dvalid && (i_mem_key == r_key);
    assign w_is_vic      = r_dvld && w_dvalid && (w_drank == w_oldest);

    // update decisions
    assign w_put       = (r_action == ACT_PUT);
    assign w_full      = (r_count >= i_cap_eff);
    assign w_slot_vic  = !r_hit && w_put && w_full && r_vic;
    assign w_slot_free = !r_hit && w_put && !w_slot_vic && r_free;
    assign w_ins       = w_slot_vic || w_slot_free;
    assign w_slot      = w_slot_vic ? r_vic_idx : r_free_idx;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and sequencer outputs
    always_comb begin
        n_state       = r_state;
        o_busy        = 1'b1;
        o_mem_rd_en   = 1'b0;
        o_res         = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_mem_rd_en = r_issue;
                if (r_dvld && (r_didx == LAST_IDX)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_res.done    = 1'b1;
                o_res.found   = r_hit;
                o_res.evicted = w_slot_vic;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_mem_rd_addr = r_idx;

    // result payload
    assign o_rd_value = (r_hit && !w_put) ? r_hit_val : '0;
    assign o_ev_key   = w_slot_vic ? r_vic_key : '0;
    assign o_occ      = n_count;

    // memory writes in the update cycle
    always_comb begin
        o_mem_wr        = '0;
        o_mem_wr_addr   = w_slot;
        o_mem_wr_key    = r_key;
        o_mem_wr_val    = r_wval;
        if (r_state == ST_UPDATE) begin
            if (r_hit) begin
                o_mem_wr.val_we = w_put;
                o_mem_wr_addr   = r_hit_idx;
            end else if (w_ins) begin
                o_mem_wr.key_we = 1'b1;
                o_mem_wr.val_we = 1'b1;
            end
        end
    end

    // item latch and scan pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_dvld  <= 1'b0;
            r_idx   <= '0;
            r_didx  <= '0;
        end else if (w_accept) begin
            r_issue <= 1'b1;
            r_dvld  <= 1'b0;
            r_idx   <= '0;
        end else if (r_state == ST_SCAN) begin
            r_dvld <= r_issue;
            r_didx <= r_idx;
            if (r_issue) begin
                if (r_idx == LAST_IDX) begin
                    r_issue <= 1'b0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
        end else begin
            r_dvld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_wval   <= i_write_value;
        end
    end

    // first hit, first least recent entry and first free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_vic  <= 1'b0;
            r_free <= 1'b0;
        end else if (w_accept) begin
            r_hit  <= 1'b0;
            r_vic  <= 1'b0;
            r_free <= 1'b0;
        end else if (r_state == ST_SCAN) begin
            if (w_match && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (w_is_vic && !r_vic) begin
                r_vic <= 1'b1;
            end
            if (r_dvld && !w_dvalid && !r_free) begin
                r_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN) begin
            if (w_match && !r_hit) begin
                r_hit_idx  <= r_didx;
                r_hit_rank <= w_drank;
                r_hit_val  <= i_mem_val;
            end
            if (w_is_vic && !r_vic) begin
                r_vic_idx <= r_didx;
                r_vic_key <= i_mem_key;
            end
            if (r_dvld && !w_dvalid && !r_free) begin
                r_free_idx <= r_didx;
            end
        end
    end

    // recency, valid and occupancy update
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (r_state == ST_UPDATE) begin
            if (r_hit) begin
                // promote: entries more recent than the hit age by one
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == r_hit_idx) begin
                        n_rank[i] = '0;
                    end else if (r_valid[i] && (r_rank[i] < r_hit_rank)) begin
                        n_rank[i] = r_rank[i] + RANK_W'(1);
                    end
                end
            end else if (w_ins) begin
                // insert as most recent, every other valid entry ages by one
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == w_slot) begin
                        n_rank[i]  = '0;
                        n_valid[i] = 1'b1;
                    end else if (r_valid[i]) begin
                        n_rank[i] = r_rank[i] + RANK_W'(1);
                    end
                end
                if (!w_slot_vic) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            r_rank[i] <= n_rank[i];
        end
    end

    // checks
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("occupancy differs from number of valid entries");

    a_update_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |=> (r_state == ST_IDLE))
        else $error("update did not return to idle");

    a_evict_only_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.evicted |-> (!o_res.found && w_put))
        else $error("eviction on a hit or a get");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.done |-> (int'(n_count) <= ENTRIES))
        else $error("occupancy beyond storage");

endmodule

// ===== design/lru_key_value_cache_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top: fully associative key/value cache, lru replacement
// capacity register, result register and the scan engine around the memories
// ----------------------------------------------------------------------------
// Usage:
//   An item (action, key, write value) is taken at a clock edge where start
//   is high and busy is low. A get returns the stored value on a hit; a put
//   updates a present key or inserts a new one, evicting the least recent
//   entry once occupancy reaches the capacity.
//   Each item sweeps all ENTRIES slots through one key/rank comparator, one
//   slot per cycle out of the registered key/value memory read port, then
//   updates ranks and memories in the update state. The result shows on
//   the o_ ports for one cycle with o_done high; busy drops in that same
//   cycle, so the next item is taken at the edge that ends it.
//   The receiver has no way to stall: each result is taken in its strobe
//   cycle.
//   Reset sets the capacity to 16 and empties the store at once. Writing the
//   capacity through i_cfg_we / i_cfg_wdata empties the store too; write it
//   only while busy is low. Capacity 0 acts as 1, above ENTRIES as ENTRIES.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top
    import lkv_pkg::*;
#(
    parameter int ENTRIES     = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_action,
    input  logic [KEY_WIDTH-1:0]         i_key,
    input  logic [VALUE_WIDTH-1:0]       i_write_value,
    input  logic                         i_cfg_we,
    input  logic [CFG_W-1:0]             i_cfg_wdata,
    output logic                         o_done,
    output logic                         o_found,
    output logic [VALUE_WIDTH-1:0]       o_read_value,
    output logic                         o_evicted,
    output logic [KEY_WIDTH-1:0]         o_evicted_key,
    output logic [$clog2(ENTRIES+1)-1:0] o_occupancy
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES+1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0] r_cap;
    logic [CMP_W-1:0] w_cap_ext;
    logic [CMP_W-1:0] w_cap_eff_ext;
    logic [CNT_W-1:0] w_cap_eff;

    logic                   w_rd_en;
    logic [IDX_W-1:0]       w_rd_addr;
    t_mem_wr                w_wr;
    logic [IDX_W-1:0]       w_wr_addr;
    logic [KEY_WIDTH-1:0]   w_wr_key;
    logic [VALUE_WIDTH-1:0] w_wr_val;
    logic [KEY_WIDTH-1:0]   w_mem_key;
    logic [VALUE_WIDTH-1:0] w_mem_val;

    t_res_flags             w_res;
    logic [VALUE_WIDTH-1:0] w_rd_value;
    logic [KEY_WIDTH-1:0]   w_ev_key;
    logic [CNT_W-1:0]       w_occ;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // effective capacity, clamped to one .. ENTRIES
    assign w_cap_ext = CMP_W'(r_cap);
    always_comb begin
        if (w_cap_ext == '0) begin
            w_cap_eff_ext = CMP_W'(1);
        end else if (w_cap_ext > CMP_W'(ENTRIES)) begin
            w_cap_eff_ext = CMP_W'(ENTRIES);
        end else begin
            w_cap_eff_ext = w_cap_ext;
        end
    end
    assign w_cap_eff = w_cap_eff_ext[CNT_W-1:0];

    lkv_mem #(
        .ENTRIES     (ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .i_wr      (w_wr),
        .i_wr_addr (w_wr_addr),
        .i_wr_key  (w_wr_key),
        .i_wr_val  (w_wr_val),
        .o_rd_key  (w_mem_key),
        .o_rd_val  (w_mem_val)
    );

    lkv_ctrl #(
        .ENTRIES     (ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_write_value (i_write_value),
        .i_clear       (i_cfg_we),
        .i_cap_eff     (w_cap_eff),
        .i_mem_key     (w_mem_key),
        .i_mem_val     (w_mem_val),
        .o_mem_rd_en   (w_rd_en),
        .o_mem_rd_addr (w_rd_addr),
        .o_mem_wr      (w_wr),
        .o_mem_wr_addr (w_wr_addr),
        .o_mem_wr_key  (w_wr_key),
        .o_mem_wr_val  (w_wr_val),
        .o_busy        (busy),
        .o_res         (w_res),
        .o_rd_value    (w_rd_value),
        .o_ev_key      (w_ev_key),
        .o_occ         (w_occ)
    );

    // result register, one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= w_res.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.done) begin
            o_found       <= w_res.found;
            o_read_value  <= w_rd_value;
            o_evicted     <= w_res.evicted;
            o_evicted_key <= w_ev_key;
            o_occupancy   <= w_occ;
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the lru key/value cache
// feeds get/put items from a queue through the start/busy handshake in bursts
// with random gaps, rewrites the capacity between phases while the cache is
// idle, and checks every result against a cycle-free shadow of the cache
// that tracks entries, recency ranks and occupancy
// ----------------------------------------------------------------------------
module testbench
    import lkv_pkg::*;
();

    localparam int ENTRIES         = 16;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int OCC_W           = $clog2(ENTRIES + 1);
    localparam int RAND_PHASES     = 12;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] wval;
    } t_access;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
        logic [OCC_W-1:0] occupancy;
    } t_reply;

    typedef enum logic {
        SK_ITEM,
        SK_CAP_WRITE
    } t_stim_kind;

    typedef struct packed {
        t_stim_kind       kind;
        logic [CFG_W-1:0] cap;
        t_access          acc;
    } t_stim;

    // dut signals
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             start         = 1'b0;
    logic             busy;
    logic             i_action      = ACT_GET;
    logic [KEY_W-1:0] i_key         = '0;
    logic [VAL_W-1:0] i_write_value = '0;
    logic             i_cfg_we      = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata   = '0;
    logic             o_done;
    logic             o_found;
    logic [VAL_W-1:0] o_read_value;
    logic             o_evicted;
    logic [KEY_W-1:0] o_evicted_key;
    logic [OCC_W-1:0] o_occupancy;

    // stimulus and scoreboard
    t_stim   stim_q[$];
    t_reply  access_results_q[$];
    logic    took_item = 1'b0;
    int      burst_left = 0;
    int      gap_left = 0;
    int      mismatches = 0;
    int      items_taken = 0;
    int      cap_writes = 0;
    int      hit_count = 0;
    int      evict_count = 0;
    int      peak_occupancy = 0;

    // shadow copy of the cache
    logic             sh_valid[ENTRIES];
    logic [KEY_W-1:0] sh_key[ENTRIES];
    logic [VAL_W-1:0] sh_val[ENTRIES];
    int unsigned      sh_rank[ENTRIES];
    int               sh_count;
    logic [CFG_W-1:0] sh_cap;

    lru_key_value_cache_top #(
        .ENTRIES     (ENTRIES),
        .KEY_WIDTH   (KEY_W),
        .VALUE_WIDTH (VAL_W)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_write_value (i_write_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_done        (o_done),
        .o_found       (o_found),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key),
        .o_occupancy   (o_occupancy)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // empty the shadow store
    function automatic void shadow_clear();
        for (int i = 0; i < ENTRIES; i++) begin
            sh_valid[i] = 1'b0;
            sh_key[i]   = '0;
            sh_val[i]   = '0;
            sh_rank[i]  = 0;
        end
        sh_count = 0;
    endfunction

    // apply one get/put to the shadow cache and return the result it gives
    function automatic t_reply shadow_cache_access(t_access a);
        t_reply      r;
        int          hit;
        int          slot;
        int          cap;
        int unsigned old_rank;
        r    = '0;
        hit  = -1;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && sh_valid[i] && sh_key[i] == a.key) hit = i;
        end
        if (hit >= 0) begin
            r.found = 1'b1;
            if (a.action == ACT_PUT) sh_val[hit] = a.wval;
            else r.read_value = sh_val[hit];
            // entries more recent than the hit age by one
            old_rank = sh_rank[hit];
            for (int i = 0; i < ENTRIES; i++) begin
                if (sh_valid[i] && sh_rank[i] < old_rank) sh_rank[i]++;
            end
            sh_rank[hit] = 0;
        end else if (a.action == ACT_PUT) begin
            cap = (sh_cap == 0) ? 1 : ((sh_cap > ENTRIES) ? ENTRIES : int'(sh_cap));
            // full: drop the least recent entry and reuse its slot
            if (sh_count >= cap) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot < 0 && sh_valid[i] && sh_rank[i] == sh_count - 1) slot = i;
                end
                if (slot >= 0) begin
                    r.evicted     = 1'b1;
                    r.evicted_key = sh_key[slot];
                    sh_valid[slot] = 1'b0;
                    sh_count--;
                end
            end
            if (slot < 0) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot < 0 && !sh_valid[i]) slot = i;
                end
            end
            if (slot >= 0) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (sh_valid[i]) sh_rank[i]++;
                end
                sh_valid[slot] = 1'b1;
                sh_key[slot]   = a.key;
                sh_val[slot]   = a.wval;
                sh_rank[slot]  = 0;
                sh_count++;
            end
        end
        r.occupancy = OCC_W'(sh_count);
        return r;
    endfunction

    // stimulus queue helpers
    function automatic void add_item(logic action, logic [KEY_W-1:0] key,
                                     logic [VAL_W-1:0] wval);
        t_stim s;
        s.kind       = SK_ITEM;
        s.cap        = '0;
        s.acc.action = action;
        s.acc.key    = key;
        s.acc.wval   = wval;
        stim_q.push_back(s);
    endfunction

    function automatic void add_cap(logic [CFG_W-1:0] cap);
        t_stim s;
        s      = '0;
        s.kind = SK_CAP_WRITE;
        s.cap  = cap;
        stim_q.push_back(s);
    endfunction

    // driver: items in bursts with random gaps, capacity writes only when idle
    always @(negedge i_clk) begin : driver
        t_stim s;
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            if (i_cfg_we) i_cfg_we <= 1'b0;
            if (start && !took_item) begin
                // item still waiting for busy to drop
            end else if (gap_left > 0) begin
                gap_left--;
                start         <= 1'b0;
                i_action      <= $urandom_range(0, 1) ? ACT_PUT : ACT_GET;
                i_key         <= $urandom;
                i_write_value <= $urandom;
            end else if (stim_q.size() == 0) begin
                start <= 1'b0;
            end else if (stim_q[0].kind == SK_CAP_WRITE) begin
                start <= 1'b0;
                if (!start && !busy && !i_cfg_we && access_results_q.size() == 0) begin
                    s = stim_q.pop_front();
                    i_cfg_we    <= 1'b1;
                    i_cfg_wdata <= s.cap;
                end
            end else begin
                s = stim_q.pop_front();
                start         <= 1'b1;
                i_action      <= s.acc.action;
                i_key         <= s.acc.key;
                i_write_value <= s.acc.wval;
                // end of burst: pick the next gap, often none
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
        end
    end

    // monitor: shadow updates on accepted items and capacity writes, result checks
    always @(posedge i_clk) begin : monitor
        t_access acc;
        t_reply  want;
        t_reply  got;
        took_item <= i_rst_n && start && !busy;
        if (!i_rst_n) begin
            sh_cap = CAP_RESET;
            shadow_clear();
        end else begin
            if (i_cfg_we) begin
                sh_cap = i_cfg_wdata;
                shadow_clear();
                cap_writes++;
            end
            if (start && !busy) begin
                acc.action = i_action;
                acc.key    = i_key;
                acc.wval   = i_write_value;
                access_results_q.push_back(shadow_cache_access(acc));
                items_taken++;
            end
            if (o_done) begin
                got.found       = o_found;
                got.read_value  = o_read_value;
                got.evicted     = o_evicted;
                got.evicted_key = o_evicted_key;
                got.occupancy   = o_occupancy;
                if (access_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with no item outstanding", $realtime);
                end else begin
                    want = access_results_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: mismatch (expected / actual)", $realtime);
                            $display("  found %b / %b  read_value %h / %h",
                                     want.found, got.found, want.read_value, got.read_value);
                            $display("  evicted %b / %b  evicted_key %h / %h",
                                     want.evicted, got.evicted,
                                     want.evicted_key, got.evicted_key);
                            $display("  occupancy %0d / %0d", want.occupancy, got.occupancy);
                        end
                    end
                    if (want.found) hit_count++;
                    if (want.evicted) evict_count++;
                    if (want.occupancy > peak_occupancy) peak_occupancy = want.occupancy;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        logic [KEY_W-1:0] key_pool[40];
        logic [CFG_W-1:0] fixed_caps[6];
        logic [CFG_W-1:0] cap;
        logic [VAL_W-1:0] wval;
        logic [KEY_W-1:0] key;
        int               eff;
        int               pool_n;

        // empty store, extreme keys and values, update of a present key
        add_item(ACT_GET, '0, '1);
        add_item(ACT_PUT, '0, '0);
        add_item(ACT_PUT, '1, '1);
        add_item(ACT_GET, '1, '0);
        add_item(ACT_GET, '0, '1);
        add_item(ACT_PUT, '1, 32'h1234_5678);
        add_item(ACT_GET, 32'h0000_0001, '0);
        add_item(ACT_GET, '1, '0);
        // capacity two: eviction of the least recent entry, recency on a get hit
        add_cap(5'd2);
        add_item(ACT_PUT, 32'hA5A5_A5A5, 32'd1);
        add_item(ACT_PUT, 32'h5A5A_5A5A, 32'd2);
        add_item(ACT_PUT, 32'hC3C3_C3C3, 32'd3);
        add_item(ACT_GET, 32'h5A5A_5A5A, '0);
        add_item(ACT_PUT, 32'h3C3C_3C3C, 32'd4);
        add_item(ACT_GET, 32'hA5A5_A5A5, '0);
        add_item(ACT_GET, 32'hC3C3_C3C3, '0);
        // zero capacity acts as one
        add_cap(5'd0);
        add_item(ACT_PUT, 32'd7, 32'd7);
        add_item(ACT_PUT, 32'd8, 32'd8);
        add_item(ACT_PUT, 32'd8, 32'd9);
        add_item(ACT_GET, 32'd8, '0);
        add_item(ACT_GET, 32'd7, '0);

        // random phases: keys from a small pool sized around the capacity
        fixed_caps = '{5'd31, 5'd1, 5'd16, 5'd17, 5'd3, 5'd8};
        for (int p = 0; p < RAND_PHASES; p++) begin
            cap = (p < 6) ? fixed_caps[p] : CFG_W'($urandom_range(0, 31));
            add_cap(cap);
            eff    = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : int'(cap));
            pool_n = $urandom_range(eff / 2 + 1, eff * 2 + 3);
            for (int k = 0; k < pool_n; k++) begin
                case ($urandom_range(0, 7))
                    0:       key_pool[k] = '0;
                    1:       key_pool[k] = '1;
                    default: key_pool[k] = $urandom;
                endcase
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom)
                                                  : key_pool[$urandom_range(0, pool_n - 1)];
                case ($urandom_range(0, 7))
                    0:       wval = '0;
                    1:       wval = '1;
                    default: wval = $urandom;
                endcase
                add_item($urandom_range(0, 1) ? ACT_PUT : ACT_GET, key, wval);
            end
        end

        // reset, then let the driver drain the queue
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        while (stim_q.size() != 0 || start || access_results_q.size() != 0)
            @(posedge i_clk);
        repeat (ENTRIES + 8) @(posedge i_clk);

        $display("covered %0d items over %0d capacity writes", items_taken, cap_writes);
        $display("%0d hits, %0d evictions, peak occupancy %0d, %0d mismatches",
                 hit_count, evict_count, peak_occupancy, mismatches);
        if (mismatches == 0 && access_results_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #8_000_000;
        $display("timeout with %0d results outstanding", access_results_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lkv_pkg.sv
design/lkv_mem.sv
design/lkv_ctrl.sv
design/lru_key_value_cache_top.sv
dv/testbench.sv
